// ----- rtl/nmea_gga_sentence_parser_macros.svh -----
// Assertion macros used by the checker file ngga_checker.sv.
`ifndef NMEA_GGA_SENTENCE_PARSER_MACROS_SVH
`define NMEA_GGA_SENTENCE_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NGGA_ASSERT_IMPLY(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define NGGA_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ----- rtl/ngga_pkg.sv -----
package ngga_pkg;

  localparam int LINE_BYTES_DEF = 128;

  // ASCII codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [39:0] GGA_NAME = "GPGGA";

  // field positions by comma count
  localparam logic [3:0] FLD_NAME    = 4'd0;
  localparam logic [3:0] FLD_TIME    = 4'd1;
  localparam logic [3:0] FLD_LAT     = 4'd2;
  localparam logic [3:0] FLD_LAT_HEM = 4'd3;
  localparam logic [3:0] FLD_LON     = 4'd4;
  localparam logic [3:0] FLD_LON_HEM = 4'd5;
  localparam logic [3:0] FLD_FIX     = 4'd6;
  localparam logic [3:0] FLD_ALT     = 4'd9;
  localparam logic [3:0] GGA_FIELDS  = 4'd10;

  localparam logic [19:0] ALT_INT_LIMIT = 20'd1000000;
  localparam logic [29:0] ALT_LIMIT     = 30'd100000000;

  typedef enum logic [3:0] {
    STAT_OTHER_OK   = 4'd0,
    STAT_FIX_UPD    = 4'd1,
    STAT_NO_FIX     = 4'd2,
    STAT_SHORT      = 4'd3,
    STAT_NO_DOLLAR  = 4'd4,
    STAT_NO_STAR    = 4'd5,
    STAT_BAD_HEX    = 4'd6,
    STAT_MISMATCH   = 4'd7,
    STAT_MISSING    = 4'd8,
    STAT_BAD_TIME   = 4'd9,
    STAT_BAD_FIX    = 4'd10,
    STAT_BAD_LAT    = 4'd11,
    STAT_BAD_LON    = 4'd12,
    STAT_BAD_ALT    = 4'd13
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_HDR, S_BODY, S_DRAIN, S_CALC1, S_CALC2, S_OUT
  } state_t;

  // what the registered read data belongs to
  typedef enum logic [2:0] {
    K_NONE, K_DOLLAR, K_HI, K_LO, K_STAR, K_BODY, K_END
  } kind_t;

  typedef enum logic [1:0] {
    AP_INT, AP_FRAC, AP_DONE
  } alt_phase_t;

endpackage

// ----- rtl/ngga_in_if.sv -----
interface ngga_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/ngga_out_if.sv -----
interface ngga_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         status;
  logic               fix_valid;
  logic [6:0]         fix_hour;
  logic [6:0]         fix_minute;
  logic [16:0]        fix_milliseconds;
  logic signed [26:0] fix_latitude;
  logic signed [30:0] fix_longitude;
  logic signed [27:0] fix_altitude_mm;

  modport source (output valid, output status, output fix_valid, output fix_hour,
                  output fix_minute, output fix_milliseconds, output fix_latitude,
                  output fix_longitude, output fix_altitude_mm, input ready);
  modport sink   (input valid, input status, input fix_valid, input fix_hour,
                  input fix_minute, input fix_milliseconds, input fix_latitude,
                  input fix_longitude, input fix_altitude_mm, output ready);
endinterface

// ----- rtl/nmea_gga_sentence_parser.sv -----
// Non-CR bytes are accepted while idle and written to the line memory; LF is dropped.
// CR: the line memory is read once per cycle (one read port), header bytes first,
// then the body (lines shorter than four bytes skip the reads); the result is
// registered once the output is free, and the next item is taken in the cycle after that.
// Reset (rst, synchronous): fill count, held fix and output valid clear to zero;
// the line memory is not cleared.
module nmea_gga_sentence_parser #(
  parameter int LINE_BYTES = ngga_pkg::LINE_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  ngga_in_if.sink    in_item,
  ngga_out_if.source out_item
);

  localparam int FW = $clog2(LINE_BYTES + 1);
  localparam int AW = $clog2(LINE_BYTES);

  // hex digit: {ok, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else                               r = 5'd0;
    return r;
  endfunction

  function automatic logic [9:0] scale3(input logic [9:0] v, input logic [2:0] n);
    logic [9:0] r;
    case (n)
      3'd1:    r = 10'(v * 10'd100);
      3'd2:    r = 10'(v * 10'd10);
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic logic [13:0] scale4(input logic [13:0] v, input logic [2:0] n);
    logic [13:0] r;
    case (n)
      3'd1:    r = 14'(v * 14'd1000);
      3'd2:    r = 14'(v * 14'd100);
      3'd3:    r = 14'(v * 14'd10);
      default: r = v;
    endcase
    return r;
  endfunction

  // line memory
  logic [7:0] mem [LINE_BYTES];
  logic [7:0] rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;

  ngga_pkg::state_t state, state_next;
  ngga_pkg::kind_t  issue_kind, tag_kind;

  logic [FW-1:0] fill_count, len, ix, pos;
  logic [1:0]    hstep;
  logic [3:0]    fld;
  logic          in_ready, in_acc, is_cr, is_lf;
  logic [FW-1:0] star;

  // header results
  logic       short_f, dollar_ok, star_ok, hi_ok, lo_ok;
  logic [3:0] hi_v, lo_v;
  logic [7:0] xsum;

  // field parse state
  logic        fstop, name_ok;
  logic        tm_bad;
  logic [6:0]  tm_h, tm_m, tm_s;
  logic [9:0]  t_fv;
  logic [2:0]  t_fn;
  logic        lat_bad, lat_hh;
  logic [6:0]  lat_d, lat_m;
  logic [13:0] lat_fv;
  logic [2:0]  lat_fn;
  logic [7:0]  lat_hc;
  logic        lon_bad, lon_hh;
  logic [9:0]  lon_d;
  logic [6:0]  lon_m;
  logic [13:0] lon_fv;
  logic [2:0]  lon_fn;
  logic [7:0]  lon_hc;
  logic        fix_has;
  logic [7:0]  fix_c;
  ngga_pkg::alt_phase_t alt_ph;
  logic        alt_neg, alt_any;
  logic [19:0] alt_ip;
  logic [9:0]  alt_fv;
  logic [2:0]  alt_fn;

  // arithmetic stages
  logic [12:0] lat_dm;
  logic [15:0] lon_dm;
  logic [13:0] lat_fs, lon_fs;
  logic [9:0]  ms_fs, alt_fs;
  logic [29:0] alt_ipk;
  logic [26:0] lat_mag;
  logic [30:0] lon_mag;
  logic [16:0] millis;
  logic [29:0] alt_mm;

  // held fix
  logic               have_fix;
  logic [6:0]         held_hour, held_minute;
  logic [16:0]        held_millis;
  logic signed [26:0] held_latitude;
  logic signed [30:0] held_longitude;
  logic signed [27:0] held_altitude;

  // output register
  logic               out_valid;
  logic [3:0]         o_status;
  logic               o_fix_valid;
  logic [6:0]         o_hour, o_minute;
  logic [16:0]        o_millis;
  logic signed [26:0] o_lat;
  logic signed [30:0] o_lon;
  logic signed [27:0] o_alt;

  // decision
  ngga_pkg::status_t stat;
  logic have_fix_next, upd, tm_ok, lat_ok, lon_ok, alt_ok, out_load;
  logic signed [26:0] lat_val;
  logic signed [30:0] lon_val;
  logic signed [27:0] alt_val;

  // byte decode
  logic [7:0]  c;
  logic [3:0]  dv;
  logic        dig;
  logic [23:0] alt_ip_x;

  assign is_cr  = in_item.rx_byte == ngga_pkg::CH_CR;
  assign is_lf  = in_item.rx_byte == ngga_pkg::CH_LF;
  assign in_acc = in_item.valid && in_ready;
  assign star   = FW'(len - FW'(3));
  assign wr_en  = in_acc && !is_cr && !is_lf;
  assign wr_addr = (fill_count >= FW'(LINE_BYTES)) ? AW'(0) : fill_count[AW-1:0];

  assign in_item.ready = in_ready;
  assign out_load = (state == ngga_pkg::S_OUT) && (!out_valid || out_item.ready);

  // sequencer: next state and read issue
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_addr    = AW'(0);
    issue_kind = ngga_pkg::K_NONE;
    case (state)
      ngga_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_acc && is_cr) begin
          state_next = (fill_count < FW'(4)) ? ngga_pkg::S_CALC1 : ngga_pkg::S_HDR;
        end
      end
      ngga_pkg::S_HDR: begin
        case (hstep)
          2'd0: begin
            rd_addr = AW'(0);
            issue_kind = ngga_pkg::K_DOLLAR;
          end
          2'd1: begin
            rd_addr = AW'(len - FW'(2));
            issue_kind = ngga_pkg::K_HI;
          end
          2'd2: begin
            rd_addr = AW'(len - FW'(1));
            issue_kind = ngga_pkg::K_LO;
          end
          default: begin
            rd_addr = star[AW-1:0];
            issue_kind = ngga_pkg::K_STAR;
            state_next = ngga_pkg::S_BODY;
          end
        endcase
      end
      ngga_pkg::S_BODY: begin
        rd_addr = ix[AW-1:0];
        if (ix < star) begin
          issue_kind = ngga_pkg::K_BODY;
        end else begin
          issue_kind = ngga_pkg::K_END;
          state_next = ngga_pkg::S_DRAIN;
        end
      end
      ngga_pkg::S_DRAIN: state_next = ngga_pkg::S_CALC1;
      ngga_pkg::S_CALC1: state_next = ngga_pkg::S_CALC2;
      ngga_pkg::S_CALC2: state_next = ngga_pkg::S_OUT;
      ngga_pkg::S_OUT: begin
        if (out_load) state_next = ngga_pkg::S_IDLE;
      end
      default: state_next = ngga_pkg::S_IDLE;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_item.rx_byte;
    rd_data <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ngga_pkg::S_IDLE;
      tag_kind   <= ngga_pkg::K_NONE;
      fill_count <= '0;
    end else begin
      state    <= state_next;
      tag_kind <= issue_kind;
      if (in_acc && is_cr) begin
        fill_count <= '0;
      end else if (wr_en) begin
        fill_count <= (fill_count >= FW'(LINE_BYTES)) ? FW'(1) : FW'(fill_count + FW'(1));
      end
    end
  end

  assign c   = rd_data;
  assign dig = (c >= ngga_pkg::CH_ZERO) && (c <= ngga_pkg::CH_NINE);
  assign dv  = 4'(c - ngga_pkg::CH_ZERO);
  assign alt_ip_x = 24'(alt_ip) * 24'd10 + 24'(dv);

  // line walk: header checks, checksum and field parse
  always_ff @(posedge clk) begin
    if (in_acc && is_cr) begin
      len <= fill_count;
      short_f <= fill_count < FW'(4);
      hstep <= 2'd0;
      ix <= FW'(1);
      pos <= '0;
      fld <= ngga_pkg::FLD_NAME;
      xsum <= 8'd0;
      fstop <= 1'b0;
      name_ok <= 1'b1;
      tm_bad <= 1'b0;  t_fn <= 3'd0;  t_fv <= '0;
      lat_bad <= 1'b0; lat_fn <= 3'd0; lat_fv <= '0; lat_hh <= 1'b0;
      lon_bad <= 1'b0; lon_fn <= 3'd0; lon_fv <= '0; lon_hh <= 1'b0;
      fix_has <= 1'b0;
      alt_ph <= ngga_pkg::AP_INT; alt_neg <= 1'b0; alt_any <= 1'b0;
      alt_ip <= '0; alt_fv <= '0; alt_fn <= 3'd0;
    end
    if (state == ngga_pkg::S_HDR) hstep <= hstep + 2'd1;
    if (state == ngga_pkg::S_BODY) ix <= ix + FW'(1);

    case (tag_kind)
      ngga_pkg::K_DOLLAR: dollar_ok <= c == ngga_pkg::CH_DOLLAR;
      ngga_pkg::K_HI: {hi_ok, hi_v} <= hex_val(c);
      ngga_pkg::K_LO: {lo_ok, lo_v} <= hex_val(c);
      ngga_pkg::K_STAR: star_ok <= c == ngga_pkg::CH_STAR;
      ngga_pkg::K_END: begin
        if (fld == ngga_pkg::FLD_NAME && pos != FW'(5)) name_ok <= 1'b0;
        if (fld < ngga_pkg::GGA_FIELDS) fld <= fld + 4'd1;
      end
      ngga_pkg::K_BODY: begin
        xsum <= xsum ^ c;
        if (c == ngga_pkg::CH_COMMA) begin
          if (fld == ngga_pkg::FLD_NAME && pos != FW'(5)) name_ok <= 1'b0;
          if (fld < ngga_pkg::GGA_FIELDS) fld <= fld + 4'd1;
          pos <= '0;
          fstop <= 1'b0;
        end else begin
          pos <= pos + FW'(1);
          case (fld)
            ngga_pkg::FLD_NAME: begin
              if (pos >= FW'(5) || c != ngga_pkg::GGA_NAME[8*(3'd4 - pos[2:0]) +: 8])
                name_ok <= 1'b0;
            end
            ngga_pkg::FLD_TIME: begin
              if (pos < FW'(6)) begin
                if (!dig) tm_bad <= 1'b1;
                case (pos[2:0])
                  3'd0: tm_h <= 7'(dv);
                  3'd1: tm_h <= 7'(tm_h * 7'd10 + 7'(dv));
                  3'd2: tm_m <= 7'(dv);
                  3'd3: tm_m <= 7'(tm_m * 7'd10 + 7'(dv));
                  3'd4: tm_s <= 7'(dv);
                  default: tm_s <= 7'(tm_s * 7'd10 + 7'(dv));
                endcase
              end else if (pos == FW'(6)) begin
                if (c != ngga_pkg::CH_DOT) tm_bad <= 1'b1;
              end else if (!fstop) begin
                if (dig && t_fn < 3'd3) begin
                  t_fv <= 10'(t_fv * 10'd10 + 10'(dv));
                  t_fn <= t_fn + 3'd1;
                end else begin
                  fstop <= 1'b1;
                end
              end
            end
            ngga_pkg::FLD_LAT: begin
              if (pos < FW'(4)) begin
                if (!dig) lat_bad <= 1'b1;
                case (pos[1:0])
                  2'd0: lat_d <= 7'(dv);
                  2'd1: lat_d <= 7'(lat_d * 7'd10 + 7'(dv));
                  2'd2: lat_m <= 7'(dv);
                  default: lat_m <= 7'(lat_m * 7'd10 + 7'(dv));
                endcase
              end else if (pos == FW'(4)) begin
                if (c != ngga_pkg::CH_DOT) lat_bad <= 1'b1;
              end else if (!fstop) begin
                if (dig && lat_fn < 3'd4) begin
                  lat_fv <= 14'(lat_fv * 14'd10 + 14'(dv));
                  lat_fn <= lat_fn + 3'd1;
                end else begin
                  fstop <= 1'b1;
                end
              end
            end
            ngga_pkg::FLD_LAT_HEM: begin
              if (pos == '0) begin
                lat_hc <= c;
                lat_hh <= 1'b1;
              end
            end
            ngga_pkg::FLD_LON: begin
              if (pos < FW'(5)) begin
                if (!dig) lon_bad <= 1'b1;
                case (pos[2:0])
                  3'd0: lon_d <= 10'(dv);
                  3'd1, 3'd2: lon_d <= 10'(lon_d * 10'd10 + 10'(dv));
                  3'd3: lon_m <= 7'(dv);
                  default: lon_m <= 7'(lon_m * 7'd10 + 7'(dv));
                endcase
              end else if (pos == FW'(5)) begin
                if (c != ngga_pkg::CH_DOT) lon_bad <= 1'b1;
              end else if (!fstop) begin
                if (dig && lon_fn < 3'd4) begin
                  lon_fv <= 14'(lon_fv * 14'd10 + 14'(dv));
                  lon_fn <= lon_fn + 3'd1;
                end else begin
                  fstop <= 1'b1;
                end
              end
            end
            ngga_pkg::FLD_LON_HEM: begin
              if (pos == '0) begin
                lon_hc <= c;
                lon_hh <= 1'b1;
              end
            end
            ngga_pkg::FLD_FIX: begin
              if (pos == '0) begin
                fix_c <= c;
                fix_has <= 1'b1;
              end
            end
            ngga_pkg::FLD_ALT: begin
              case (alt_ph)
                ngga_pkg::AP_INT: begin
                  if (pos == '0 && (c == ngga_pkg::CH_PLUS || c == ngga_pkg::CH_MINUS)) begin
                    alt_neg <= c == ngga_pkg::CH_MINUS;
                  end else if (dig) begin
                    alt_ip <= (alt_ip_x > 24'(ngga_pkg::ALT_INT_LIMIT)) ?
                              ngga_pkg::ALT_INT_LIMIT : 20'(alt_ip_x);
                    alt_any <= 1'b1;
                  end else if (c == ngga_pkg::CH_DOT) begin
                    alt_ph <= ngga_pkg::AP_FRAC;
                  end else begin
                    alt_ph <= ngga_pkg::AP_DONE;
                  end
                end
                ngga_pkg::AP_FRAC: begin
                  if (dig && alt_fn < 3'd3) begin
                    alt_fv <= 10'(alt_fv * 10'd10 + 10'(dv));
                    alt_fn <= alt_fn + 3'd1;
                  end else begin
                    alt_ph <= ngga_pkg::AP_DONE;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    // arithmetic, stage one: degrees to minutes, fraction scaling
    if (state == ngga_pkg::S_CALC1) begin
      lat_dm  <= 13'(lat_d) * 13'd60 + 13'(lat_m);
      lon_dm  <= 16'(lon_d) * 16'd60 + 16'(lon_m);
      lat_fs  <= scale4(lat_fv, lat_fn);
      lon_fs  <= scale4(lon_fv, lon_fn);
      ms_fs   <= scale3(t_fv, t_fn);
      alt_fs  <= scale3(alt_fv, alt_fn);
      alt_ipk <= 30'(alt_ip) * 30'd1000;
    end
    // stage two: final magnitudes
    if (state == ngga_pkg::S_CALC2) begin
      lat_mag <= 27'(lat_dm) * 27'd10000 + 27'(lat_fs);
      lon_mag <= 31'(lon_dm) * 31'd10000 + 31'(lon_fs);
      millis  <= 17'(tm_s) * 17'd1000 + 17'(ms_fs);
      alt_mm  <= (alt_ipk + 30'(alt_fs) > ngga_pkg::ALT_LIMIT) ?
                 ngga_pkg::ALT_LIMIT : alt_ipk + 30'(alt_fs);
    end
  end

  // verdict in priority order
  assign tm_ok  = !tm_bad && t_fn != 3'd0;
  assign lat_ok = !lat_bad && lat_fn != 3'd0 && lat_hh &&
                  (lat_hc == ngga_pkg::CH_N || lat_hc == ngga_pkg::CH_S);
  assign lon_ok = !lon_bad && lon_fn != 3'd0 && lon_hh &&
                  (lon_hc == ngga_pkg::CH_E || lon_hc == ngga_pkg::CH_W);
  assign alt_ok = alt_any || alt_fn != 3'd0;
  assign lat_val = (lat_hc == ngga_pkg::CH_S) ? -$signed(lat_mag) : $signed(lat_mag);
  assign lon_val = (lon_hc == ngga_pkg::CH_W) ? -$signed(lon_mag) : $signed(lon_mag);
  assign alt_val = alt_neg ? -$signed(28'(alt_mm)) : $signed(28'(alt_mm));

  always_comb begin
    have_fix_next = have_fix;
    upd = 1'b0;
    if (short_f) stat = ngga_pkg::STAT_SHORT;
    else if (!dollar_ok) stat = ngga_pkg::STAT_NO_DOLLAR;
    else if (!star_ok) stat = ngga_pkg::STAT_NO_STAR;
    else if (!hi_ok || !lo_ok) stat = ngga_pkg::STAT_BAD_HEX;
    else if (xsum != {hi_v, lo_v}) stat = ngga_pkg::STAT_MISMATCH;
    else if (!name_ok) stat = ngga_pkg::STAT_OTHER_OK;
    else if (fld < ngga_pkg::GGA_FIELDS) stat = ngga_pkg::STAT_MISSING;
    else if (!tm_ok) stat = ngga_pkg::STAT_BAD_TIME;
    else if (!fix_has) stat = ngga_pkg::STAT_BAD_FIX;
    else if (fix_c == ngga_pkg::CH_ZERO) begin
      have_fix_next = 1'b0;
      stat = ngga_pkg::STAT_NO_FIX;
    end else if (fix_c != ngga_pkg::CH_ONE && fix_c != ngga_pkg::CH_TWO) begin
      stat = ngga_pkg::STAT_BAD_FIX;
    end else begin
      have_fix_next = 1'b1;
      if (!lat_ok) stat = ngga_pkg::STAT_BAD_LAT;
      else if (!lon_ok) stat = ngga_pkg::STAT_BAD_LON;
      else if (!alt_ok) stat = ngga_pkg::STAT_BAD_ALT;
      else begin
        stat = ngga_pkg::STAT_FIX_UPD;
        upd = 1'b1;
      end
    end
  end

  // held fix and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      have_fix       <= 1'b0;
      held_hour      <= '0;
      held_minute    <= '0;
      held_millis    <= '0;
      held_latitude  <= '0;
      held_longitude <= '0;
      held_altitude  <= '0;
    end else begin
      if (out_valid && out_item.ready) out_valid <= 1'b0;
      if (out_load) begin
        out_valid <= 1'b1;
        have_fix  <= have_fix_next;
        if (upd) begin
          held_hour      <= tm_h;
          held_minute    <= tm_m;
          held_millis    <= millis;
          held_latitude  <= lat_val;
          held_longitude <= lon_val;
          held_altitude  <= alt_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_status    <= stat;
      o_fix_valid <= have_fix_next;
      o_hour      <= upd ? tm_h    : held_hour;
      o_minute    <= upd ? tm_m    : held_minute;
      o_millis    <= upd ? millis  : held_millis;
      o_lat       <= upd ? lat_val : held_latitude;
      o_lon       <= upd ? lon_val : held_longitude;
      o_alt       <= upd ? alt_val : held_altitude;
    end
  end

  assign out_item.valid            = out_valid;
  assign out_item.status           = o_status;
  assign out_item.fix_valid        = o_fix_valid;
  assign out_item.fix_hour         = o_hour;
  assign out_item.fix_minute       = o_minute;
  assign out_item.fix_milliseconds = o_millis;
  assign out_item.fix_latitude     = o_lat;
  assign out_item.fix_longitude    = o_lon;
  assign out_item.fix_altitude_mm  = o_alt;

endmodule

// ----- rtl/ngga_checker.sv -----
`include "nmea_gga_sentence_parser_macros.svh"

module ngga_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         status,
  input logic               fix_valid,
  input logic signed [27:0] fix_altitude_mm
);

  // a waiting result item holds
  `NGGA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(fix_altitude_mm), "result changed while stalled")
  // status code in range
  `NGGA_ASSERT_IMPLY(a_status_range, clk, rst, out_valid, status <= ngga_pkg::STAT_BAD_ALT, "status out of range")
  // an updated fix always reports the fix flag
  `NGGA_ASSERT_IMPLY(a_upd_flag, clk, rst, out_valid && status == ngga_pkg::STAT_FIX_UPD, fix_valid, "fix update without fix flag")
  // a no-fix sentence clears the flag
  `NGGA_ASSERT_IMPLY(a_nofix_flag, clk, rst, out_valid && status == ngga_pkg::STAT_NO_FIX, !fix_valid, "no-fix sentence left fix flag set")
  // altitude saturates
  `NGGA_ASSERT_IMPLY(a_alt_range, clk, rst, out_valid, fix_altitude_mm <= 28'sd100000000 && fix_altitude_mm >= -28'sd100000000, "altitude beyond limit")

endmodule

bind nmea_gga_sentence_parser ngga_checker u_ngga_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_item.valid),
  .out_ready       (out_item.ready),
  .status          (out_item.status),
  .fix_valid       (out_item.fix_valid),
  .fix_altitude_mm (out_item.fix_altitude_mm)
);

// ----- tb/nmea_gga_sentence_parser_checker.sv -----
module nmea_gga_sentence_parser_checker (
  input  logic clk,
  input  logic rst,
  ngga_in_if   in_mon,
  ngga_out_if  out_mon,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ngga_pkg::*;

  localparam int STORE_BYTES = 128;
  localparam int FIELD_COUNT = 10;
  localparam int ALT_MAX_MM = 100000000;

  typedef struct {
    status_t            status;
    bit                 fix_valid;
    bit [6:0]           hour;
    bit [6:0]           minute;
    bit [16:0]          millis;
    logic signed [26:0] lat;
    logic signed [30:0] lon;
    logic signed [27:0] alt;
  } fix_report_t;

  fix_report_t report_q[$];

  // model state
  logic [7:0] line_mem [0:STORE_BYTES-1];
  int fill;
  bit held_valid;
  int held_hour, held_minute, held_millis, held_lat, held_lon, held_alt;

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit hex_val(logic [7:0] c, output int v);
    v = 0;
    if (is_dig(c)) v = c - "0";
    else if (c >= "A" && c <= "F") v = c - "A" + 10;
    else if (c >= "a" && c <= "f") v = c - "a" + 10;
    else return 0;
    return 1;
  endfunction

  function automatic bit take_digits(inout int p, input int e, input int n, output int v);
    v = 0;
    for (int i = 0; i < n; i++) begin
      if (p >= e || !is_dig(line_mem[p])) return 0;
      v = v * 10 + (line_mem[p] - "0");
      p++;
    end
    return 1;
  endfunction

  // one to places digits, scaled up to places
  function automatic bit take_frac(inout int p, input int e, input int places, output int v);
    int n;
    n = 0;
    v = 0;
    while (n < places && p < e && is_dig(line_mem[p])) begin
      v = v * 10 + (line_mem[p] - "0");
      n++;
      p++;
    end
    if (n == 0) return 0;
    for (; n < places; n++) v = v * 10;
    return 1;
  endfunction

  function automatic bit take_dot(inout int p, input int e);
    if (p >= e || line_mem[p] != CH_DOT) return 0;
    p++;
    return 1;
  endfunction

  function automatic bit decode_angle(int s, int e, int dd, int hs, int he,
                                      logic [7:0] pos_c, logic [7:0] neg_c, output int v);
    int p, d, m, f;
    p = s;
    v = 0;
    if (!take_digits(p, e, dd, d)) return 0;
    if (!take_digits(p, e, 2, m)) return 0;
    if (!take_dot(p, e)) return 0;
    if (!take_frac(p, e, 4, f)) return 0;
    if (hs >= he) return 0;
    v = (d * 60 + m) * 10000 + f;
    if (line_mem[hs] == neg_c) v = -v;
    else if (line_mem[hs] != pos_c) return 0;
    return 1;
  endfunction

  function automatic bit decode_alt(int s, int e, output int v);
    int p, fr, digits;
    longint ip, mm;
    bit neg;
    p = s;
    ip = 0;
    fr = 0;
    digits = 0;
    neg = 0;
    v = 0;
    if (p < e && (line_mem[p] == CH_PLUS || line_mem[p] == CH_MINUS)) begin
      neg = line_mem[p] == CH_MINUS;
      p++;
    end
    while (p < e && is_dig(line_mem[p])) begin
      ip = ip * 10 + (line_mem[p] - "0");
      if (ip > 1000000) ip = 1000000;
      digits++;
      p++;
    end
    if (p < e && line_mem[p] == CH_DOT) begin
      p++;
      if (take_frac(p, e, 3, fr)) digits++;
    end
    if (digits == 0) return 0;
    mm = ip * 1000 + fr;
    if (mm > ALT_MAX_MM) mm = ALT_MAX_MM;
    v = neg ? -int'(mm) : int'(mm);
    return 1;
  endfunction

  // checks and decodes the held line, updating the held fix
  function automatic status_t decode_line(int len);
    int star, sum, hi, lo, nf, cur, p, h, mi, sec, ms, lat, lon, alt;
    int fs [FIELD_COUNT];
    int fe [FIELD_COUNT];
    logic [7:0] fc;
    if (len < 4) return STAT_SHORT;
    if (line_mem[0] != CH_DOLLAR) return STAT_NO_DOLLAR;
    star = len - 3;
    if (line_mem[star] != CH_STAR) return STAT_NO_STAR;
    sum = 0;
    for (int i = 1; i < star; i++) sum ^= line_mem[i];
    if (!hex_val(line_mem[len-2], hi) || !hex_val(line_mem[len-1], lo)) return STAT_BAD_HEX;
    if (sum != (hi * 16 + lo)) return STAT_MISMATCH;
    nf = 0;
    cur = 1;
    for (int i = 0; i < FIELD_COUNT; i++) begin
      fs[i] = 0;
      fe[i] = 0;
    end
    for (int i = 1; i <= star; i++) begin
      if (i == star || line_mem[i] == CH_COMMA) begin
        if (nf < FIELD_COUNT) begin
          fs[nf] = cur;
          fe[nf] = i;
        end
        nf++;
        cur = i + 1;
      end
    end
    if (fe[0] - fs[0] != 5) return STAT_OTHER_OK;
    for (int i = 0; i < 5; i++)
      if (line_mem[fs[0]+i] != GGA_NAME[39-8*i -: 8]) return STAT_OTHER_OK;
    if (nf < FIELD_COUNT) return STAT_MISSING;
    p = fs[1];
    if (!take_digits(p, fe[1], 2, h) || !take_digits(p, fe[1], 2, mi) ||
        !take_digits(p, fe[1], 2, sec) || !take_dot(p, fe[1]) ||
        !take_frac(p, fe[1], 3, ms))
      return STAT_BAD_TIME;
    if (fs[6] >= fe[6]) return STAT_BAD_FIX;
    fc = line_mem[fs[6]];
    if (fc == CH_ZERO) begin
      held_valid = 0;
      return STAT_NO_FIX;
    end
    if (fc != CH_ONE && fc != CH_TWO) return STAT_BAD_FIX;
    held_valid = 1;
    if (!decode_angle(fs[2], fe[2], 2, fs[3], fe[3], CH_N, CH_S, lat)) return STAT_BAD_LAT;
    if (!decode_angle(fs[4], fe[4], 3, fs[5], fe[5], CH_E, CH_W, lon)) return STAT_BAD_LON;
    if (!decode_alt(fs[9], fe[9], alt)) return STAT_BAD_ALT;
    held_hour = h;
    held_minute = mi;
    held_millis = sec * 1000 + ms;
    held_lat = lat;
    held_lon = lon;
    held_alt = alt;
    return STAT_FIX_UPD;
  endfunction

  assign pending = report_q.size();

  // predict on accepted input items, compare on accepted results
  always @(posedge clk) begin
    fix_report_t exp_r;
    status_t st;
    if (rst) begin
      fill <= 0;
      held_valid = 0;
      held_hour = 0;
      held_minute = 0;
      held_millis = 0;
      held_lat = 0;
      held_lon = 0;
      held_alt = 0;
    end else begin
      if (in_mon.valid && in_mon.ready && in_mon.rx_byte != CH_LF) begin
        if (in_mon.rx_byte != CH_CR) begin
          if (fill >= STORE_BYTES) begin
            line_mem[0] = in_mon.rx_byte;
            fill <= 1;
          end else begin
            line_mem[fill] = in_mon.rx_byte;
            fill <= fill + 1;
          end
        end else begin
          st = decode_line(fill);
          fill <= 0;
          exp_r.status = st;
          exp_r.fix_valid = held_valid;
          exp_r.hour = held_hour[6:0];
          exp_r.minute = held_minute[6:0];
          exp_r.millis = held_millis[16:0];
          exp_r.lat = held_lat[26:0];
          exp_r.lon = held_lon[30:0];
          exp_r.alt = held_alt[27:0];
          report_q.push_back(exp_r);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (report_q.size() == 0) begin
          $display("%0t: unexpected result, status %0d", $time, out_mon.status);
          errors <= errors + 1;
        end else begin
          exp_r = report_q.pop_front();
          if (out_mon.status !== exp_r.status ||
              out_mon.fix_valid !== exp_r.fix_valid ||
              out_mon.fix_hour !== exp_r.hour ||
              out_mon.fix_minute !== exp_r.minute ||
              out_mon.fix_milliseconds !== exp_r.millis ||
              out_mon.fix_latitude !== exp_r.lat ||
              out_mon.fix_longitude !== exp_r.lon ||
              out_mon.fix_altitude_mm !== exp_r.alt) begin
            $display("%0t: mismatch exp st=%0d v=%0d %0d:%0d ms=%0d lat=%0d lon=%0d alt=%0d",
                     $time, exp_r.status, exp_r.fix_valid, exp_r.hour, exp_r.minute,
                     exp_r.millis, exp_r.lat, exp_r.lon, exp_r.alt);
            $display("%0t:          got st=%0d v=%0d %0d:%0d ms=%0d lat=%0d lon=%0d alt=%0d",
                     $time, out_mon.status, out_mon.fix_valid, out_mon.fix_hour,
                     out_mon.fix_minute, out_mon.fix_milliseconds, out_mon.fix_latitude,
                     out_mon.fix_longitude, out_mon.fix_altitude_mm);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  initial begin
    errors = 0;
    fill = 0;
  end
endmodule

// ----- tb/nmea_gga_sentence_parser_tb.sv -----
module nmea_gga_sentence_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 0;
  logic rst = 1;
  int errors, pending, cycles;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  ngga_in_if  in_item();
  ngga_out_if out_item();

  nmea_gga_sentence_parser dut (.clk(clk), .rst(rst), .in_item(in_item), .out_item(out_item));

  nmea_gga_sentence_parser_checker checker_i (
    .clk(clk), .rst(rst), .in_mon(in_item), .out_mon(out_item),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_item.valid = 0;
    in_item.rx_byte = 0;
    out_item.ready = 0;
  end

  // receiver stalls
  always @(posedge clk) out_item.ready <= ($urandom_range(99) >= recv_stall_pct);

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end
  initial cycles = 0;

  task automatic put_byte(logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_item.valid <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_item.valid <= 1;
    in_item.rx_byte <= b;
    do @(posedge clk); while (!in_item.ready);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // line then CR, sometimes LF after it
  task automatic put_line(string s);
    put_text(s);
    put_byte(ngga_pkg::CH_CR);
    if ($urandom_range(1)) put_byte(ngga_pkg::CH_LF);
  endtask

  // framed sentence with its checksum, optionally lowercase or wrong
  task automatic put_sentence(string body, bit lower = 0, bit wrong = 0);
    logic [7:0] sum;
    sum = 0;
    for (int i = 0; i < body.len(); i++) sum ^= body[i];
    if (wrong) sum ^= 8'(1 << $urandom_range(7));
    put_line({"$", body, "*", lower ? $sformatf("%02x", sum) : $sformatf("%02X", sum)});
  endtask

  function automatic string digs(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
    return s;
  endfunction

  function automatic string junk(int n);
    string pool, s;
    pool = "0123456789.,NSEWA+-*$";
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(pool[$urandom_range(pool.len() - 1)])};
    return s;
  endfunction

  // well-formed position report with random content, sometimes one field damaged
  function automatic string random_gga();
    string f [14];
    string body;
    int sel;
    f[0] = "GPGGA";
    f[1] = {digs(6), ".", digs($urandom_range(1, 3)), $urandom_range(4) == 0 ? digs(2) : ""};
    f[2] = {digs(4), ".", digs($urandom_range(1, 4))};
    f[3] = $urandom_range(1) ? "N" : "S";
    f[4] = {digs(5), ".", digs($urandom_range(1, 4))};
    f[5] = $urandom_range(1) ? "E" : "W";
    sel = $urandom_range(9);
    f[6] = sel == 0 ? "0" : (sel < 5 ? "1" : "2");
    f[7] = digs(2);
    f[8] = {digs(1), ".", digs(1)};
    sel = $urandom_range(4);
    f[9] = {sel == 0 ? "-" : (sel == 1 ? "+" : ""),
            digs($urandom_range(0, 4)), $urandom_range(1) ? {".", digs($urandom_range(0, 4))} : ""};
    if (f[9] == "" || f[9] == "-" || f[9] == "+") f[9] = {f[9], "7"};
    if ($urandom_range(19) == 0) f[9] = digs(9);
    f[10] = "M";
    f[11] = digs(2);
    f[12] = "M";
    f[13] = "";
    if ($urandom_range(6) == 0) f[$urandom_range(1, 9)] = junk($urandom_range(0, 3));
    body = f[0];
    for (int i = 1; i < 14; i++) body = {body, ",", f[i]};
    return body;
  endfunction

  task automatic random_part(int n);
    int kind;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        put_sentence(random_gga(), $urandom_range(1), $urandom_range(19) == 0);
      end else if (kind < 80) begin
        put_sentence({"GPRMC,", junk($urandom_range(0, 20))});
      end else if (kind < 97) begin
        // raw noise bytes of any value except line ends
        for (int i = $urandom_range(0, 20); i > 0; i--) begin
          logic [7:0] b;
          b = $urandom_range(255);
          if (b == ngga_pkg::CH_CR || b == ngga_pkg::CH_LF) b = 8'hFF;
          put_byte(b);
        end
        put_byte(ngga_pkg::CH_CR);
      end else begin
        // runs past the store size before the CR
        for (int i = $urandom_range(129, 200); i > 0; i--) put_byte(8'($urandom_range(32, 126)));
        put_sentence(random_gga());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: framing errors, every status, field extremes
    put_line("");
    put_line("$A*");
    put_line("X,GPGGA*00");
    put_line("$GPGGA,1");
    put_line("$A*G1");
    put_line("$A*4g");
    put_sentence("GPGGA,123519.5,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,", 1);
    put_sentence("GPGGA,000000.000,9959.9999,S,99959.9999,W,2,,,-12.3456,M,,M,,");
    put_sentence("GPGGA,235959.99,0000.1,N,00000.1,E,1,,,+99999999.9");
    put_sentence("GPGGA,010203.4,0000.0,N,00000.0,E,1,,,.5");
    put_sentence("GPGGA,123519.5,4807.038,N,01131.000,E,1,08,0.9,545.4", 0, 1);
    put_sentence("GPGSV,1,2,3");
    put_sentence("GPGGAX,1,2");
    put_sentence("GPGGA,123519.5,4807.038,N");
    put_sentence("GPGGA,12345.1,4807.038,N,01131.000,E,1,08,0.9,545.4");
    put_sentence("GPGGA,123519.,4807.038,N,01131.000,E,1,08,0.9,545.4");
    put_sentence("GPGGA,123519.5,4807.038,N,01131.000,E,0,08,0.9,545.4");
    put_sentence("GPGGA,123519.5,4807.038,N,01131.000,E,,08,0.9,545.4");
    put_sentence("GPGGA,123519.5,4807.038,N,01131.000,E,X,08,0.9,545.4");
    put_sentence("GPGGA,123519.5,48x7.038,N,01131.000,E,1,08,0.9,545.4");
    put_sentence("GPGGA,123519.5,4807.038,N,01131.000,N,1,08,0.9,545.4");
    put_sentence("GPGGA,123519.5,4807.038,N,01131.000,E,2,08,0.9,-");
    put_text("$GP\nGGA");
    put_line("*00");
    for (int i = 0; i < 130; i++) put_byte(8'h80 + 8'(i % 128));
    put_sentence("A");
    in_item.valid <= 0;

    // hold off until all results are back
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    send_idle_pct = 0;  recv_stall_pct = 0;  random_part(2);
    send_idle_pct = 64; recv_stall_pct = 0;  random_part(2);
    send_idle_pct = 0;  recv_stall_pct = 64; random_part(2);
    send_idle_pct = 34; recv_stall_pct = 34; random_part(2);
    in_item.valid <= 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ngga_pkg.sv
rtl/ngga_in_if.sv
rtl/ngga_out_if.sv
rtl/nmea_gga_sentence_parser.sv
rtl/ngga_checker.sv
tb/nmea_gga_sentence_parser_checker.sv
tb/nmea_gga_sentence_parser_tb.sv
